// ===== rtl/fdh_pkg.sv =====
// ----------------------------------------------------------------------------
// fdh_pkg
// Shared types and constants for the filtered dual histogram core.
// ----------------------------------------------------------------------------
package fdh_pkg;

  localparam int T_BINS_DEF      = 4096;
  localparam int X_BINS_DEF      = 2048;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [11:0] LATTICE_RESET = 12'd4095;

  localparam logic [1:0] MODE_RECORD  = 2'd0;
  localparam logic [1:0] MODE_READ_T  = 2'd1;
  localparam logic [1:0] MODE_READ_X  = 2'd2;
  localparam logic [1:0] MODE_SUMMARY = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_T_REJECT = 2'd1;
  localparam logic [1:0] STATUS_X_RANGE  = 2'd2;
  localparam logic [1:0] STATUS_IDX_BAD  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] t_value;
    logic signed [31:0] s_value;
    logic signed [31:0] a_value;
    logic signed [31:0] x_value;
    logic [11:0]        bin_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        bin_count;
    logic signed [31:0] t_maximum;
    logic signed [31:0] s_maximum;
    logic signed [31:0] a_maximum;
    logic signed [31:0] x_maximum;
    logic [31:0]        total_points;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/fdh_ram.sv =====
// ----------------------------------------------------------------------------
// fdh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdh_ram #(
  parameter int WIDTH = fdh_pkg::COUNT_WIDTH_DEF,
  parameter int DEPTH = fdh_pkg::T_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fdh_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdh_ctrl
// Sequencer: clearing pass, item capture, bin lookup, update and result.
// ----------------------------------------------------------------------------
module fdh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fdh_pkg::stat_t stat,
  output fdh_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    LOOKUP,
    FINISH
  } state_t;

  state_t state;
  logic   in_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= CLEAR;
      in_rdy <= 1'b0;
    end else begin
      unique case (state)
        CLEAR: begin
          if (stat.clr_last) begin
            state  <= IDLE;
            in_rdy <= 1'b1;
          end
        end
        IDLE: begin
          if (in_valid) begin
            state  <= LOOKUP;
            in_rdy <= 1'b0;
          end
        end
        LOOKUP: begin
          state <= FINISH;
        end
        FINISH: begin
          if (stat.out_free) begin
            state  <= IDLE;
            in_rdy <= 1'b1;
          end
        end
        default: begin
          state  <= CLEAR;
          in_rdy <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready    = in_rdy;
  assign cmd.clear   = (state == CLEAR);
  assign cmd.capture = in_rdy && in_valid;
  assign cmd.finish  = (state == FINISH) && stat.out_free;

endmodule

// ===== rtl/fdh_datapath.sv =====
// ----------------------------------------------------------------------------
// fdh_datapath
// Item registers, bin RAMs, range checks, maxima, total and result register.
// ----------------------------------------------------------------------------
module fdh_datapath #(
  parameter int T_BINS      = fdh_pkg::T_BINS_DEF,
  parameter int X_BINS      = fdh_pkg::X_BINS_DEF,
  parameter int COUNT_WIDTH = fdh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fdh_pkg::cmd_t       cmd,
  output fdh_pkg::stat_t      stat,
  input  fdh_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  input  logic [11:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fdh_pkg::out_item_t  out_data
);

  localparam int TA        = $clog2(T_BINS);
  localparam int XA        = $clog2(X_BINS);
  localparam int CLR_DEPTH = (T_BINS > X_BINS) ? T_BINS : X_BINS;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

  logic [11:0]            lattice;
  fdh_pkg::in_item_t      item;
  logic [CLR_AW-1:0]      clr_addr;
  logic signed [31:0]     t_peak, s_peak, a_peak, x_peak;
  logic [COUNT_WIDTH-1:0] total, total_next;
  fdh_pkg::out_item_t     result;

  logic [31:0]            t_u, x_u;
  logic                   is_rec, t_ok, x_ok, t_idx_ok, x_idx_ok, upd;
  logic                   clr_x_in;
  logic [TA-1:0]          t_raddr, t_waddr;
  logic [XA-1:0]          x_raddr, x_waddr;
  logic                   t_we, x_we;
  logic [COUNT_WIDTH-1:0] t_rdata, x_rdata, t_wdata, x_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice <= fdh_pkg::LATTICE_RESET;
    end else if (cfg_valid) begin
      lattice <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  // clearing pass over both bin RAMs
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !stat.clr_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign stat.clr_last = (clr_addr == CLR_AW'(CLR_DEPTH - 1));
  assign clr_x_in      = ({1'b0, clr_addr} < (CLR_AW + 1)'(X_BINS));

  assign t_u      = item.t_value;
  assign x_u      = item.x_value;
  assign is_rec   = (item.mode == fdh_pkg::MODE_RECORD);
  assign t_ok     = !t_u[31] && (t_u != 32'd0) && (t_u <= {20'd0, lattice})
                    && (t_u < 32'(T_BINS));
  assign x_ok     = !x_u[31] && (x_u < 32'(X_BINS));
  assign t_idx_ok = (item.bin_index <= lattice) && ({20'd0, item.bin_index} < 32'(T_BINS));
  assign x_idx_ok = ({20'd0, item.bin_index} < 32'(X_BINS));
  assign upd      = cmd.finish && is_rec && t_ok;

  assign t_raddr = is_rec ? TA'(t_u) : TA'(item.bin_index);
  assign x_raddr = is_rec ? XA'(x_u) : XA'(item.bin_index);

  assign t_we    = cmd.clear || upd;
  assign t_waddr = cmd.clear ? TA'(clr_addr) : t_raddr;
  assign t_wdata = cmd.clear ? '0 : sat_inc(t_rdata);
  assign x_we    = (cmd.clear && clr_x_in) || (upd && x_ok);
  assign x_waddr = cmd.clear ? XA'(clr_addr) : x_raddr;
  assign x_wdata = cmd.clear ? '0 : sat_inc(x_rdata);

  fdh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(T_BINS)) u_t_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  fdh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(X_BINS)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  assign total_next = upd ? sat_inc(total) : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_peak <= '0;
      s_peak <= '0;
      a_peak <= '0;
      x_peak <= '0;
      total  <= '0;
    end else begin
      total <= total_next;
      if (upd) begin
        if (item.t_value > t_peak) t_peak <= item.t_value;
        if (item.s_value > s_peak) s_peak <= item.s_value;
        if (item.a_value > a_peak) a_peak <= item.a_value;
        if (item.x_value > x_peak) x_peak <= item.x_value;
      end
    end
  end

  always_comb begin
    result              = '0;
    result.total_points = 32'(total_next);
    unique case (item.mode)
      fdh_pkg::MODE_RECORD: begin
        if (!t_ok) begin
          result.status = fdh_pkg::STATUS_T_REJECT;
        end else if (!x_ok) begin
          result.status = fdh_pkg::STATUS_X_RANGE;
        end else begin
          result.status = fdh_pkg::STATUS_OK;
        end
      end
      fdh_pkg::MODE_READ_T: begin
        if (!t_idx_ok) begin
          result.status = fdh_pkg::STATUS_IDX_BAD;
        end else begin
          result.bin_count = (item.bin_index == 12'd0) ? 32'(total) : 32'(t_rdata);
        end
      end
      fdh_pkg::MODE_READ_X: begin
        if (!x_idx_ok) begin
          result.status = fdh_pkg::STATUS_IDX_BAD;
        end else begin
          result.bin_count = (item.bin_index == 12'd0) ? 32'(total) : 32'(x_rdata);
        end
      end
      fdh_pkg::MODE_SUMMARY: begin
        result.bin_count = 32'(total);
        result.t_maximum = t_peak;
        result.s_maximum = s_peak;
        result.a_maximum = a_peak;
        result.x_maximum = x_peak;
      end
      default: begin
        result.status = fdh_pkg::STATUS_OK;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= result;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/filtered_dual_histogram_core.sv =====
// ----------------------------------------------------------------------------
// filtered_dual_histogram_core
// Filtered t/x histogram accumulator with running maxima and total count.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_ready  | in_data  (fdh_pkg::in_item_t)
//  out     | out_valid / out_ready| out_data (fdh_pkg::out_item_t)
//  cfg     | cfg_valid / cfg_ready| cfg_data (lattice_size)
//
//  Items pass capture, bin RAM read, and read-modify-write of the bin
//  RAMs together with loading the result register; the next item is
//  taken only once the last one is through. After reset a clearing pass
//  over max(T_BINS, X_BINS) addresses zeroes both bin RAMs; no item is
//  taken during it, cfg writes are. The result register lets the next
//  item in while a result waits; its update step stalls while that is held.
// ----------------------------------------------------------------------------
module filtered_dual_histogram_core #(
  parameter int T_BINS      = fdh_pkg::T_BINS_DEF,
  parameter int X_BINS      = fdh_pkg::X_BINS_DEF,
  parameter int COUNT_WIDTH = fdh_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fdh_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [11:0]        cfg_data
);

  fdh_pkg::cmd_t  cmd;
  fdh_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  fdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdh_datapath #(
    .T_BINS      (T_BINS),
    .X_BINS      (X_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_result_on_return: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded without returning to idle");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (!in_ready && !out_valid && !cmd.finish))
    else $error("activity during clearing pass");

endmodule

// ===== verif/fdh_reply_checker.sv =====
// ----------------------------------------------------------------------------
// fdh_reply_checker
// Watches the in, out and cfg channels of filtered_dual_histogram_core. Each
// item taken on the in channel is run through a cycle-free model of the two
// histograms, the running maxima and the total. The predicted reply is queued,
// and each reply taken on the out channel is compared field by field with the
// oldest queued one. Mismatches and the number of replies still due go to the
// top.
// ----------------------------------------------------------------------------
module fdh_reply_checker
  import fdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [11:0] cfg_data,
  output int          awaited,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int T_BINS = T_BINS_DEF;
  localparam int X_BINS = X_BINS_DEF;

  logic [31:0]        t_hist [T_BINS];
  logic [31:0]        x_hist [X_BINS];
  logic signed [31:0] t_peak, s_peak, a_peak, x_peak;
  logic [31:0]        records;
  logic [11:0]        lattice;
  out_item_t          awaited_replies [$];
  int                 reply_no;

  initial begin
    awaited = 0;
    mismatches = 0;
    reply_no = 0;
  end

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic out_item_t predict_reply(in_item_t it);
    out_item_t r;
    int        tv;
    int        xv;
    r  = '0;
    tv = it.t_value;
    xv = it.x_value;
    case (it.mode)
      MODE_RECORD: begin
        if (tv <= 0 || tv > int'(lattice) || tv >= T_BINS) begin
          r.status = STATUS_T_REJECT;
        end else begin
          if (it.t_value > t_peak) t_peak = it.t_value;
          if (it.s_value > s_peak) s_peak = it.s_value;
          if (it.a_value > a_peak) a_peak = it.a_value;
          if (it.x_value > x_peak) x_peak = it.x_value;
          t_hist[tv] = bump(t_hist[tv]);
          if (xv >= 0 && xv < X_BINS) x_hist[xv] = bump(x_hist[xv]);
          else r.status = STATUS_X_RANGE;
          records = bump(records);
        end
      end
      MODE_READ_T: begin
        if (it.bin_index > lattice || int'(it.bin_index) >= T_BINS)
          r.status = STATUS_IDX_BAD;
        else
          r.bin_count = (it.bin_index == 0) ? records : t_hist[it.bin_index];
      end
      MODE_READ_X: begin
        if (int'(it.bin_index) >= X_BINS)
          r.status = STATUS_IDX_BAD;
        else
          r.bin_count = (it.bin_index == 0) ? records : x_hist[it.bin_index];
      end
      default: begin
        r.bin_count = records;
        r.t_maximum = t_peak;
        r.s_maximum = s_peak;
        r.a_maximum = a_peak;
        r.x_maximum = x_peak;
      end
    endcase
    r.total_points = records;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("reply %0d %s: got %h, want %h", reply_no, name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < T_BINS; i++) t_hist[i] = '0;
      for (int i = 0; i < X_BINS; i++) x_hist[i] = '0;
      t_peak  = '0;
      s_peak  = '0;
      a_peak  = '0;
      x_peak  = '0;
      records = '0;
      lattice = LATTICE_RESET;
      awaited_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d arrived with none due", reply_no));
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("bin_count", out_data.bin_count, want.bin_count);
          check_field("t_maximum", out_data.t_maximum, want.t_maximum);
          check_field("s_maximum", out_data.s_maximum, want.s_maximum);
          check_field("a_maximum", out_data.a_maximum, want.a_maximum);
          check_field("x_maximum", out_data.x_maximum, want.x_maximum);
          check_field("total_points", out_data.total_points, want.total_points);
        end
        reply_no++;
      end
      if (cfg_valid && cfg_ready) lattice = cfg_data;
      if (in_valid && in_ready) awaited_replies.push_back(predict_reply(in_data));
    end
    awaited = awaited_replies.size();
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for filtered_dual_histogram_core. It starts with directed records
// and reads at the field extremes, then runs random phases under several
// lattice sizes (zero, one, small, mid, full, random). Sender idling and
// receiver stalls vary by phase, with one long receiver hold-off and sender
// pauses until all replies are back. Checking is in fdh_reply_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdh_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int END_CYCLES  = 12;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;

  int          awaited;
  int          mismatches;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_off = 1'b0;
  logic [11:0] cur_lattice = LATTICE_RESET;

  filtered_dual_histogram_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fdh_reply_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .awaited    (awaited),
    .mismatches (mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("filtered_dual_histogram_core verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off so the core fills and drops in_ready
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  function automatic in_item_t record_item(logic signed [31:0] t, logic signed [31:0] s,
                                           logic signed [31:0] a, logic signed [31:0] x);
    in_item_t it;
    it = '0;
    it.mode    = MODE_RECORD;
    it.t_value = t;
    it.s_value = s;
    it.a_value = a;
    it.x_value = x;
    return it;
  endfunction

  function automatic in_item_t read_item(logic [1:0] m, logic [11:0] idx);
    in_item_t it;
    it = '0;
    it.mode      = m;
    it.bin_index = idx;
    return it;
  endfunction

  function automatic in_item_t make_item(logic [11:0] lat);
    in_item_t    it;
    int unsigned hi;
    int unsigned r;
    hi = (lat == 12'd0) ? 32'd1 : 32'(lat);
    it.s_value = ($urandom_range(3) == 0) ? $urandom_range(1000) : $urandom;
    it.a_value = ($urandom_range(3) == 0) ? $urandom_range(1000) : $urandom;
    r = $urandom_range(9);
    if (r < 5) it.mode = MODE_RECORD;
    else if (r < 7) it.mode = MODE_READ_T;
    else if (r < 9) it.mode = MODE_READ_X;
    else it.mode = MODE_SUMMARY;

    r = $urandom_range(9);
    if (r < 4) it.t_value = $urandom_range((hi < 16) ? hi : 16, 1);
    else if (r < 6) it.t_value = $urandom_range(hi, 1);
    else if (r == 6) begin
      case ($urandom_range(7))
        0: it.t_value = 0;
        1: it.t_value = 32'(lat);
        2: it.t_value = 32'(lat) + 1;
        3: it.t_value = 4095;
        4: it.t_value = 4096;
        5: it.t_value = -1;
        6: it.t_value = S_MIN;
        default: it.t_value = S_MAX;
      endcase
    end else it.t_value = $urandom;

    r = $urandom_range(9);
    if (r < 5) it.x_value = $urandom_range(15);
    else if (r < 7) it.x_value = $urandom_range(2047);
    else if (r == 7) begin
      case ($urandom_range(5))
        0: it.x_value = 2047;
        1: it.x_value = 2048;
        2: it.x_value = -1;
        3: it.x_value = S_MIN;
        4: it.x_value = S_MAX;
        default: it.x_value = 0;
      endcase
    end else it.x_value = $urandom;

    r = $urandom_range(9);
    if (r < 5) it.bin_index = 12'($urandom_range(16));
    else if (r == 5) begin
      case ($urandom_range(5))
        0: it.bin_index = lat;
        1: it.bin_index = lat + 12'd1;
        2: it.bin_index = 12'd0;
        3: it.bin_index = 12'd2047;
        4: it.bin_index = 12'd2048;
        default: it.bin_index = 12'd4095;
      endcase
    end else if (r < 8) it.bin_index = 12'($urandom_range(lat));
    else it.bin_index = 12'($urandom_range(4095));
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic write_lattice(logic [11:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_lattice = v;
  endtask

  task automatic run_phase(logic [11:0] lat, int idle, int stall, int n);
    wait_drained();
    write_lattice(lat);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) send_item(make_item(cur_lattice));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, lattice at reset value
    send_item(read_item(MODE_SUMMARY, 12'd0));
    send_item(read_item(MODE_READ_T, 12'd0));
    send_item(record_item(1, S_MIN, -1, 0));
    send_item(record_item(4095, S_MAX, 5, 2047));
    send_item(record_item(0, S_MAX, S_MAX, 100));
    send_item(record_item(-1, S_MAX, S_MAX, 100));
    send_item(record_item(4096, S_MAX, S_MAX, 100));
    send_item(record_item(S_MAX, S_MAX, S_MAX, 100));
    send_item(record_item(S_MIN, S_MAX, S_MAX, 100));
    send_item(record_item(5, 3, 3, 2048));
    send_item(record_item(5, 3, 3, -1));
    send_item(record_item(5, 3, 3, S_MIN));
    send_item(record_item(7, 0, S_MAX, S_MAX));
    send_item(read_item(MODE_READ_T, 12'd5));
    send_item(read_item(MODE_READ_T, 12'd4095));
    send_item(read_item(MODE_READ_X, 12'd0));
    send_item(read_item(MODE_READ_X, 12'd2047));
    send_item(read_item(MODE_READ_X, 12'd2048));
    send_item(read_item(MODE_READ_X, 12'd4095));
    send_item(read_item(MODE_READ_T, 12'd1));
    send_item(read_item(MODE_READ_X, 12'd5));
    send_item(read_item(MODE_SUMMARY, 12'd0));
    repeat (100) send_item(make_item(cur_lattice));

    run_phase(12'd1, 68, 0, 60);
    run_phase(12'd0, 0, 68, 40);
    run_phase(12'd40, 35, 35, 20);
    // sender keeps offering items while the receiver holds off
    hold_go = 1'b1;
    repeat (100) send_item(make_item(cur_lattice));
    run_phase(LATTICE_RESET, 0, 0, 80);
    wait_drained();
    repeat (60) send_item(make_item(cur_lattice));
    run_phase(12'($urandom_range(4095, 1)), 68, 0, 100);
    run_phase(12'd2047, 0, 68, 100);

    wait_drained();
    repeat (END_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("filtered_dual_histogram_core verification clean");
    else
      $display("filtered_dual_histogram_core verification failed");
    $finish;
  end

endmodule
